@@ src/mrpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpc_pkg: shared types and constants of the region protection checker
// Transfer payloads, operation and status codes, register indexes and the
// control groups passed between the region table and the result logic.
// ----------------------------------------------------------------------------
package mrpc_pkg;

   localparam int REGIONS_DEFAULT = 16;

   localparam int ADDR_W   = 64;
   localparam int ID_W     = 32;
   localparam int PERM_W   = 2;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int LEAK_W   = 5;
   localparam int unsigned LEAK_MAX = 31;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   typedef enum logic [OP_W-1:0] {
      OP_CHECK  = 2'd0,
      OP_GRANT  = 2'd1,
      OP_REVOKE = 2'd2,
      OP_LEAK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_UNMAPPED  = 3'd2,
      ST_OOB       = 3'd3,
      ST_NO_PERM   = 3'd4,
      ST_OVERLAP   = 3'd5,
      ST_NOT_ALLOC = 3'd6,
      ST_FULL      = 3'd7
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHECK_ENABLE      = 1'b0,
      CSR_LEAK_CHECK_ENABLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] length;
      logic [PERM_W-1:0] perms;
      logic              perms_any;
      logic [ID_W-1:0]   region_id;
      logic              permanent;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                wrong_size;
      logic                wrong_perms;
      logic                wrong_id;
      logic [ADDR_W-1:0]   region_base;
      logic [ADDR_W-1:0]   region_length;
      logic [LEAK_W-1:0]   leak_count;
   } rsp_type;

   // Lookup results of the table for the item in the input register.
   typedef struct packed {
      logic              hold_hit;
      logic              ovl_hit;
      logic              free_hit;
      logic [ADDR_W-1:0] sel_base;
      logic [ADDR_W-1:0] sel_length;
      logic [PERM_W-1:0] sel_perms;
      logic [ID_W-1:0]   sel_ident;
      logic [LEAK_W-1:0] leak_count;
   } match_type;

   // Table update requested by the result logic.
   typedef struct packed {
      logic grant;
      logic revoke;
   } cmd_type;

endpackage

@@ src/memory_region_protection_checker.sv @@
`timescale 1ns / 1ps
// Pipeline: an accepted request is loaded into the input register and its
// response then into the response register, which offers it until taken.
// Throughput: one request per cycle while the response is not stalled; the
// table is updated at the same edge that registers the response, so the
// next request sees the new table.
// Reset (synchronous, active high) empties the region table, zeroes the leak
// count and sets both enable registers to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
// memory_region_protection_checker: region table protection checker
// Grants, revokes and checks accesses against a table of disjoint regions
// and reports the number of non-permanent regions still held.
// ----------------------------------------------------------------------------
module memory_region_protection_checker #(
   parameter int REGIONS = mrpc_pkg::REGIONS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mrpc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mrpc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [mrpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mrpc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic                in_valid_ff;
   mrpc_pkg::req_type   in_data_ff;
   logic                rsp_valid_ff;
   mrpc_pkg::rsp_type   rsp_data_ff;
   mrpc_pkg::rsp_type   rsp_in;
   mrpc_pkg::match_type match;
   mrpc_pkg::cmd_type   cmd;
   logic                check_enable_ff;
   logic                leak_check_enable_ff;
   logic                advance;
   logic                step;

   // move the response register when it is empty or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         check_enable_ff      <= 1'b1;
         leak_check_enable_ff <= 1'b1;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= in_valid_ff;
         if (csr_write_enable) begin
            unique case (mrpc_pkg::csr_index_type'(csr_index))
               mrpc_pkg::CSR_CHECK_ENABLE:      check_enable_ff      <= csr_write_data[0];
               mrpc_pkg::CSR_LEAK_CHECK_ENABLE: leak_check_enable_ff <= csr_write_data[0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (step) rsp_data_ff <= rsp_in;
   end

   mrpc_region_table #(
      .REGIONS (REGIONS)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .item  (in_data_ff),
      .step  (step),
      .cmd   (cmd),
      .match (match)
   );

   mrpc_result_logic u_result (
      .item              (in_data_ff),
      .match             (match),
      .check_enable      (check_enable_ff),
      .leak_check_enable (leak_check_enable_ff),
      .rsp               (rsp_in),
      .cmd               (cmd)
   );

endmodule

@@ src/mrpc_region_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpc_region_table: region entries with per-entry match lanes
// Each entry compares the current item in parallel; priority encoders pick
// the lowest matching, overlapping and free entries. Also keeps the running
// count of valid non-permanent regions.
// ----------------------------------------------------------------------------
module mrpc_region_table #(
   parameter int REGIONS = mrpc_pkg::REGIONS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  mrpc_pkg::req_type   item,
   input  logic                step,
   input  mrpc_pkg::cmd_type   cmd,
   output mrpc_pkg::match_type match
);

   localparam int IDX_W      = $clog2(REGIONS);
   localparam int LEAK_CNT_W = $clog2(REGIONS + 1);

   logic [REGIONS-1:0]                 valid_ff;
   logic [REGIONS-1:0]                 valid_in;
   logic [mrpc_pkg::ADDR_W-1:0]        base_ff   [REGIONS];
   logic [mrpc_pkg::ADDR_W-1:0]        length_ff [REGIONS];
   logic [mrpc_pkg::PERM_W-1:0]        perms_ff  [REGIONS];
   logic [mrpc_pkg::ID_W-1:0]          ident_ff  [REGIONS];
   logic [REGIONS-1:0]                 permanent_ff;
   logic [LEAK_CNT_W-1:0]              leak_cnt_ff;
   logic [LEAK_CNT_W-1:0]              leak_cnt_in;

   logic [REGIONS-1:0]                 hold_vec;
   logic [REGIONS-1:0]                 ovl_vec;
   logic [REGIONS-1:0]                 free_vec;
   logic [IDX_W-1:0]                   hold_idx;
   logic [IDX_W-1:0]                   ovl_idx;
   logic [IDX_W-1:0]                   free_idx;
   logic [IDX_W-1:0]                   sel_idx;
   logic [mrpc_pkg::ADDR_W-1:0]        item_end;
   logic                               is_grant;

   assign item_end = item.address + item.length;
   assign is_grant = (mrpc_pkg::op_type'(item.opcode) == mrpc_pkg::OP_GRANT);

   // Match lanes, one per entry.
   always_comb begin
      for (int i = 0; i < REGIONS; i++) begin
         hold_vec[i] = valid_ff[i] && (item.address >= base_ff[i]) &&
                       ((item.address - base_ff[i]) < length_ff[i]);
         ovl_vec[i]  = valid_ff[i] && (item.address < (base_ff[i] + length_ff[i])) &&
                       (base_ff[i] < item_end);
         free_vec[i] = !valid_ff[i];
      end
   end

   // Lowest index wins.
   always_comb begin
      hold_idx = '0;
      ovl_idx  = '0;
      free_idx = '0;
      for (int i = REGIONS - 1; i >= 0; i--) begin
         if (hold_vec[i]) hold_idx = IDX_W'(i);
         if (ovl_vec[i])  ovl_idx  = IDX_W'(i);
         if (free_vec[i]) free_idx = IDX_W'(i);
      end
   end

   assign sel_idx = is_grant ? ovl_idx : hold_idx;

   always_comb begin
      match.hold_hit   = |hold_vec;
      match.ovl_hit    = |ovl_vec;
      match.free_hit   = |free_vec;
      match.sel_base   = base_ff[sel_idx];
      match.sel_length = length_ff[sel_idx];
      match.sel_perms  = perms_ff[sel_idx];
      match.sel_ident  = ident_ff[sel_idx];
      match.leak_count = (32'(leak_cnt_ff) > mrpc_pkg::LEAK_MAX) ?
                         mrpc_pkg::LEAK_W'(mrpc_pkg::LEAK_MAX) :
                         mrpc_pkg::LEAK_W'(leak_cnt_ff);
   end

   always_comb begin
      valid_in    = valid_ff;
      leak_cnt_in = leak_cnt_ff;
      if (step && cmd.grant) begin
         valid_in[free_idx] = 1'b1;
         if (!item.permanent) leak_cnt_in = leak_cnt_ff + LEAK_CNT_W'(1);
      end
      if (step && cmd.revoke) begin
         valid_in[sel_idx] = 1'b0;
         if (!permanent_ff[sel_idx]) leak_cnt_in = leak_cnt_ff - LEAK_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         leak_cnt_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         leak_cnt_ff <= leak_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && cmd.grant) begin
         base_ff[free_idx]      <= item.address;
         length_ff[free_idx]    <= item.length;
         perms_ff[free_idx]     <= item.perms;
         ident_ff[free_idx]     <= item.region_id;
         permanent_ff[free_idx] <= item.permanent;
      end
   end

endmodule

@@ src/mrpc_result_logic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpc_result_logic: per-operation decision logic
// Turns the item and the table lookup into the result transfer and the
// table update for check, grant, revoke and leak count.
// ----------------------------------------------------------------------------
module mrpc_result_logic (
   input  mrpc_pkg::req_type   item,
   input  mrpc_pkg::match_type match,
   input  logic                check_enable,
   input  logic                leak_check_enable,
   output mrpc_pkg::rsp_type   rsp,
   output mrpc_pkg::cmd_type   cmd
);

   logic [mrpc_pkg::ADDR_W:0]   end_sum;
   logic [mrpc_pkg::ADDR_W-1:0] end_addr;
   logic [mrpc_pkg::ADDR_W-1:0] region_end;
   logic                        wrap;
   logic                        len_any;
   logic                        len_zero;

   assign end_sum    = {1'b0, item.address} + {1'b0, item.length};
   assign end_addr   = end_sum[mrpc_pkg::ADDR_W-1:0];
   assign wrap       = end_sum[mrpc_pkg::ADDR_W];
   assign len_any    = &item.length;
   assign len_zero   = (item.length == '0);
   assign region_end = match.sel_base + match.sel_length;

   always_comb begin
      rsp = '0;
      cmd = '0;
      unique case (mrpc_pkg::op_type'(item.opcode))
         mrpc_pkg::OP_CHECK: begin
            if (check_enable) begin
               if (!len_any && wrap) begin
                  rsp.status = mrpc_pkg::ST_BAD_SIZE;
               end else if (!match.hold_hit) begin
                  rsp.status = mrpc_pkg::ST_UNMAPPED;
               end else begin
                  rsp.region_base   = match.sel_base;
                  rsp.region_length = match.sel_length;
                  // an all-ones length that wraps runs past every region end
                  if (wrap || (end_addr > region_end)) begin
                     rsp.status = mrpc_pkg::ST_OOB;
                  end else if ((item.perms & match.sel_perms) != item.perms) begin
                     rsp.status = mrpc_pkg::ST_NO_PERM;
                  end
               end
            end
         end
         mrpc_pkg::OP_GRANT: begin
            if (len_zero || wrap) begin
               rsp.status = mrpc_pkg::ST_BAD_SIZE;
            end else if (match.ovl_hit) begin
               rsp.status        = mrpc_pkg::ST_OVERLAP;
               rsp.region_base   = match.sel_base;
               rsp.region_length = match.sel_length;
            end else if (!match.free_hit) begin
               rsp.status = mrpc_pkg::ST_FULL;
            end else begin
               cmd.grant         = 1'b1;
               rsp.region_base   = item.address;
               rsp.region_length = item.length;
            end
         end
         mrpc_pkg::OP_REVOKE: begin
            if (!len_any && wrap) begin
               rsp.status = mrpc_pkg::ST_BAD_SIZE;
            end else if (!match.hold_hit) begin
               rsp.status = mrpc_pkg::ST_NOT_ALLOC;
            end else begin
               rsp.region_base   = match.sel_base;
               rsp.region_length = match.sel_length;
               if (match.sel_base != item.address) begin
                  rsp.status = mrpc_pkg::ST_NOT_ALLOC;
               end else begin
                  // drop the entry even when a compare fails
                  cmd.revoke      = 1'b1;
                  rsp.wrong_size  = !len_any && (match.sel_length != item.length);
                  rsp.wrong_perms = !item.perms_any && (match.sel_perms != item.perms);
                  rsp.wrong_id    = !(&item.region_id) &&
                                    (match.sel_ident != item.region_id);
               end
            end
         end
         mrpc_pkg::OP_LEAK: begin
            if (leak_check_enable) rsp.leak_count = match.leak_count;
         end
      endcase
   end

endmodule

@@ src/mrpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpc_checker: port-level assertions for the region protection checker
// Watches the response channel for handshake rules and for field
// combinations that no operation can produce.
// ----------------------------------------------------------------------------
module mrpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mrpc_pkg::rsp_type rsp_data
);

   // a held response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("stalled response payload changed");

   // revoke mismatch flags and leak counts only come with status ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.wrong_size || rsp_data.wrong_perms || rsp_data.wrong_id ||
                    (rsp_data.leak_count != '0))
      |-> (rsp_data.status == mrpc_pkg::ST_OK))
      else $error("mismatch flag or leak count with error status");

   // no region is named when the size is bad, nothing is mapped or the table is full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == mrpc_pkg::ST_BAD_SIZE) ||
                    (rsp_data.status == mrpc_pkg::ST_UNMAPPED) ||
                    (rsp_data.status == mrpc_pkg::ST_FULL))
      |-> (rsp_data.region_base == '0) && (rsp_data.region_length == '0))
      else $error("region fields set on a status that names no region");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind memory_region_protection_checker mrpc_checker u_mrpc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
